// ===== design/sal_pkg.sv =====
// ----------------------------------------------------------------------------
// sal_pkg
// Shared types and constants for the source address lockout table.
// ----------------------------------------------------------------------------
`default_nettype none

package sal_pkg;

    localparam int TABLE_ENTRIES = 8;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    localparam int ADDR_W     = 32;
    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 8;
    localparam int LOCK_SEC_W = 17;
    localparam int FUNC_W     = 2;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LOCKOUT   = 1'd1;

    localparam logic [COUNT_W-1:0]    THRESHOLD_RESET = 8'd3;
    localparam logic [LOCK_SEC_W-1:0] LOCKOUT_RESET   = 17'd300;
    localparam logic [COUNT_W-1:0]    COUNT_MAX       = 8'd255;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CHECK  = 2'd0,
        FUNC_RECORD = 2'd1,
        FUNC_CLEAR  = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic start;   // latch request, restart scan
        logic step;    // examine one entry
        logic commit;  // apply update, load result
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic hit;       // current entry matches request address
        logic last;      // current entry is the last one
        logic out_free;  // result register can take a beat this cycle
    } t_dp_status;

endpackage

`default_nettype wire

// ===== design/sal_datapath.sv =====
// ----------------------------------------------------------------------------
// sal_datapath
// Entry table, scan index, update logic, config registers and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sal_datapath import sal_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_status                 o_status,
    input  wire logic [FUNC_W-1:0]     i_func,
    input  wire logic [ADDR_W-1:0]     i_source_address,
    input  wire logic [TIME_W-1:0]     i_time_now,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic                       o_allowed,
    output logic                       o_entry_found,
    output logic                       o_now_locked
);

    // request
    logic [FUNC_W-1:0]     r_req_func;
    logic [ADDR_W-1:0]     r_req_addr;
    logic [TIME_W-1:0]     r_req_time;
    logic [TIME_W-1:0]     r_lock_end_new;

    // config
    logic [COUNT_W-1:0]    r_threshold;
    logic [LOCK_SEC_W-1:0] r_lockout_sec;

    // scan
    logic [IDX_W-1:0]      r_idx;
    logic                  r_found;
    logic [IDX_W-1:0]      r_match_idx;
    logic                  r_empty_found;
    logic [IDX_W-1:0]      r_empty_idx;

    // table
    logic [ADDR_W-1:0]        r_tab_addr  [TABLE_ENTRIES];
    logic [COUNT_W-1:0]       r_tab_count [TABLE_ENTRIES];
    logic [TIME_W-1:0]        r_tab_end   [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_tab_valid;

    // result
    logic r_out_valid;
    logic r_out_allowed;
    logic r_out_found;
    logic r_out_locked;

    logic [ADDR_W-1:0]  scan_addr;
    logic               scan_empty;
    logic [COUNT_W-1:0] m_count;
    logic [TIME_W-1:0]  m_end;
    logic [COUNT_W-1:0] inc_count;
    logic [TIME_W:0]    lock_sum;

    logic               wr_en;
    logic               wr_valid;
    logic [IDX_W-1:0]   wr_idx;
    logic [COUNT_W-1:0] wr_count;
    logic [TIME_W-1:0]  wr_end;
    logic               res_allowed;
    logic               res_found;
    logic               res_locked;

    // an entry without its valid bit reads as empty
    assign scan_addr  = r_tab_valid[r_idx] ? r_tab_addr[r_idx] : '0;
    assign scan_empty = (scan_addr == '0);

    assign o_status.hit      = (scan_addr == r_req_addr);
    assign o_status.last     = (r_idx == IDX_W'(TABLE_ENTRIES - 1));
    assign o_status.out_free = !r_out_valid || i_ready;

    assign m_count   = r_tab_valid[r_match_idx] ? r_tab_count[r_match_idx] : '0;
    assign m_end     = r_tab_valid[r_match_idx] ? r_tab_end[r_match_idx] : '0;
    assign inc_count = (m_count == COUNT_MAX) ? m_count : m_count + COUNT_W'(1);
    assign lock_sum  = {1'b0, r_req_time} + (TIME_W + 1)'(r_lockout_sec);

    always_comb begin
        res_allowed = 1'b1;
        res_found   = 1'b0;
        res_locked  = 1'b0;
        wr_en       = 1'b0;
        wr_valid    = 1'b1;
        wr_idx      = r_match_idx;
        wr_count    = inc_count;
        wr_end      = m_end;
        case (r_req_func)
            FUNC_CHECK: begin
                if (r_found) begin
                    res_found = 1'b1;
                    if (m_end != '0) begin
                        if (r_req_time < m_end) begin
                            res_allowed = 1'b0;
                        end else begin
                            // lockout over: drop the entry
                            wr_en    = 1'b1;
                            wr_valid = 1'b0;
                        end
                    end
                end
            end
            FUNC_RECORD: begin
                wr_en = 1'b1;
                if (r_found) begin
                    res_found = 1'b1;
                    if (inc_count >= r_threshold) begin
                        wr_end     = r_lock_end_new;
                        res_locked = 1'b1;
                    end
                end else begin
                    // new entry: first empty slot, else slot zero
                    wr_idx   = r_empty_found ? r_empty_idx : '0;
                    wr_count = COUNT_W'(1);
                    wr_end   = '0;
                end
            end
            FUNC_CLEAR: begin
                if (r_found) begin
                    res_found = 1'b1;
                    wr_en     = 1'b1;
                    wr_valid  = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // request and scan payload
    always_ff @(posedge i_clk) begin
        r_lock_end_new <= lock_sum[TIME_W] ? '1 : lock_sum[TIME_W-1:0];
        if (i_cmd.start) begin
            r_req_func <= i_func;
            r_req_addr <= i_source_address;
            r_req_time <= i_time_now;
        end
        if (i_cmd.step) begin
            if (o_status.hit) begin
                r_match_idx <= r_idx;
            end else if (scan_empty && !r_empty_found) begin
                r_empty_idx <= r_idx;
            end
        end
        if (i_cmd.commit && wr_en) begin
            r_tab_addr[wr_idx]  <= r_req_addr;
            r_tab_count[wr_idx] <= wr_count;
            r_tab_end[wr_idx]   <= wr_end;
        end
        if (i_cmd.commit) begin
            r_out_allowed <= res_allowed;
            r_out_found   <= res_found;
            r_out_locked  <= res_locked;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx         <= '0;
            r_found       <= 1'b0;
            r_empty_found <= 1'b0;
            r_tab_valid   <= '0;
            r_out_valid   <= 1'b0;
            r_threshold   <= THRESHOLD_RESET;
            r_lockout_sec <= LOCKOUT_RESET;
        end else begin
            if (i_cmd.start) begin
                r_idx         <= '0;
                r_found       <= 1'b0;
                r_empty_found <= 1'b0;
            end else if (i_cmd.step) begin
                if (o_status.hit) begin
                    r_found <= 1'b1;
                end else begin
                    if (scan_empty) begin
                        r_empty_found <= 1'b1;
                    end
                    if (!o_status.last) begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
            end
            if (i_cmd.commit && wr_en) begin
                r_tab_valid[wr_idx] <= wr_valid;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_IDX_THRESHOLD: r_threshold   <= i_cfg_data[COUNT_W-1:0];
                    CFG_IDX_LOCKOUT:   r_lockout_sec <= i_cfg_data[LOCK_SEC_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_allowed     = r_out_allowed;
    assign o_entry_found = r_out_found;
    assign o_now_locked  = r_out_locked;

`ifndef NO_ASSERTIONS
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= IDX_W'(TABLE_ENTRIES - 1))
        else $error("scan index beyond table");

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_out_valid || i_ready))
        else $error("commit while result register is full");

    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_valid)
        else $error("result not presented after commit");
`endif

endmodule

`default_nettype wire

// ===== design/sal_ctrl.sv =====
// ----------------------------------------------------------------------------
// sal_ctrl
// Sequencer: accept a request, scan the table, commit the update.
// ----------------------------------------------------------------------------
`default_nettype none

module sal_ctrl import sal_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_status.hit || i_status.last) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready      = 1'b0;
        o_cmd.start  = 1'b0;
        o_cmd.step   = 1'b0;
        o_cmd.commit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready     = 1'b1;
                o_cmd.start = i_valid;
            end
            S_SCAN: begin
                o_cmd.step = 1'b1;
            end
            S_UPDATE: begin
                o_cmd.commit = i_status.out_free;
            end
            default: begin
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) && i_valid |=> (r_state == S_SCAN))
        else $error("accepted beat did not start a scan");

    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) && (i_status.hit || i_status.last) |=> (r_state == S_UPDATE))
        else $error("scan did not end on hit or last entry");

    a_commit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> (r_state == S_IDLE))
        else $error("commit did not return to idle");
`endif

endmodule

`default_nettype wire

// ===== design/source_address_lockout_table.sv =====
// ----------------------------------------------------------------------------
// source_address_lockout_table
// Per-source failed login table: check, record failure, clear on success.
// An accepted beat is scanned in S_SCAN up to the matching entry, or to the
//   last entry when nothing matches; the scan visits one entry per cycle.
// S_UPDATE commits once the result register is free; only then is a new request taken.
// Reset: synchronous; all table entries empty at once, threshold 3, lockout 300 s.
// ----------------------------------------------------------------------------
`default_nettype none

module source_address_lockout_table import sal_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [FUNC_W-1:0]     i_func,
    input  wire logic [ADDR_W-1:0]     i_source_address,
    input  wire logic [TIME_W-1:0]     i_time_now,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic                       o_allowed,
    output logic                       o_entry_found,
    output logic                       o_now_locked,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    sal_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (dp_status),
        .o_cmd    (dp_cmd)
    );

    sal_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_status         (dp_status),
        .i_func           (i_func),
        .i_source_address (i_source_address),
        .i_time_now       (i_time_now),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_allowed        (o_allowed),
        .o_entry_found    (o_entry_found),
        .o_now_locked     (o_now_locked)
    );

endmodule

`default_nettype wire
